[design/bps_pkg.sv]
package bps_pkg;

    localparam int DURATION_BITS = 16;
    localparam int COUNT_BITS    = 8;
    localparam int TICKS_BITS    = 16;

    typedef logic [DURATION_BITS-1:0] t_dur;
    typedef logic [COUNT_BITS-1:0]    t_count;

    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_START = 1'b1
    } t_req_kind;

    typedef struct packed {
        t_req_kind             req_type;
        logic [COUNT_BITS-1:0] beep_count;
        logic [TICKS_BITS-1:0] on_ticks;
        logic [TICKS_BITS-1:0] off_ticks;
    } t_req;

    typedef struct packed {
        logic buzzer_level;
        logic burst_active;
    } t_res;

    localparam t_dur DUR_MAX = {DURATION_BITS{1'b1}};

    function automatic t_dur to_dur(input logic [TICKS_BITS-1:0] v);
        logic [DURATION_BITS+TICKS_BITS-1:0] ext;
        begin
            ext = {{DURATION_BITS{1'b0}}, v};
            return ext[DURATION_BITS-1:0];
        end
    endfunction

endpackage

[design/bps_core.sv]
module bps_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  bps_pkg::t_req i_req,
    output bps_pkg::t_res o_res
);

    logic            r_running;
    logic            r_phase_on;
    bps_pkg::t_count r_beeps;
    bps_pkg::t_dur   r_elapsed;
    bps_pkg::t_dur   r_on_len;
    bps_pkg::t_dur   r_off_len;

    logic            n_running;
    logic            n_phase_on;
    bps_pkg::t_count n_beeps;
    bps_pkg::t_dur   n_elapsed;
    bps_pkg::t_dur   n_on_len;
    bps_pkg::t_dur   n_off_len;

    bps_pkg::t_dur   phase_len;
    bps_pkg::t_dur   elapsed_inc;
    bps_pkg::t_count beeps_dec;

    always_comb begin
        phase_len   = r_phase_on ? r_on_len : r_off_len;
        elapsed_inc = (r_elapsed != bps_pkg::DUR_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        beeps_dec   = r_beeps - 1'b1;

        n_running  = r_running;
        n_phase_on = r_phase_on;
        n_beeps    = r_beeps;
        n_elapsed  = r_elapsed;
        n_on_len   = r_on_len;
        n_off_len  = r_off_len;

        case (i_req.req_type)
            bps_pkg::REQ_START: begin
                if (!r_running) begin
                    n_running  = 1'b1;
                    n_phase_on = 1'b1;
                    n_beeps    = i_req.beep_count;
                    n_elapsed  = '0;
                    n_on_len   = bps_pkg::to_dur(i_req.on_ticks);
                    n_off_len  = bps_pkg::to_dur(i_req.off_ticks);
                end
            end
            bps_pkg::REQ_TICK: begin
                if (r_running) begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc >= phase_len) begin
                        n_elapsed = '0;
                        if (r_phase_on) begin
                            n_beeps = beeps_dec;
                            if (beeps_dec != '0) begin
                                n_phase_on = 1'b0;
                            end else begin
                                n_running = 1'b0;
                            end
                        end else begin
                            n_phase_on = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_running = r_running;
            end
        endcase

        o_res.buzzer_level = n_running & n_phase_on;
        o_res.burst_active = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_phase_on <= 1'b0;
            r_beeps    <= '0;
            r_elapsed  <= '0;
            r_on_len   <= '0;
            r_off_len  <= '0;
        end else if (i_fire) begin
            r_running  <= n_running;
            r_phase_on <= n_phase_on;
            r_beeps    <= n_beeps;
            r_elapsed  <= n_elapsed;
            r_on_len   <= n_on_len;
            r_off_len  <= n_off_len;
        end
    end

endmodule

[design/beep_pattern_sequencer_unit.sv]
// Channel   Direction  Payload           Handshake
// input     in         bps_pkg::t_req    i_in_valid / o_in_stall
// result    out        bps_pkg::t_res    o_out_valid / i_out_stall
//
// Every input transfer gives exactly one result transfer, through the input register r_in and then r_out.
// One item is taken per cycle while the result side is not stalled; a stalled result is the only limit.
// Reset is synchronous and active low; it clears the burst state and both valids.
// A stalled result holds the input register, which then stalls the input side.
module beep_pattern_sequencer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bps_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bps_pkg::t_res o_out_data
);

    logic          r_in_valid;
    bps_pkg::t_req r_in;
    logic          r_out_valid;
    bps_pkg::t_res r_out;

    logic          out_free;
    logic          core_fire;
    logic          in_take;
    bps_pkg::t_res core_res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign core_fire  = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    bps_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (core_fire),
        .i_req   (r_in),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= core_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (core_fire) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_buzzer_needs_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.buzzer_level || o_out_data.burst_active))
        else $error("buzzer sounding without an active burst");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while the pipeline could move");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_fire |=> o_out_valid)
        else $error("processed item produced no result");

    a_take_loads_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted transfer lost from the input register");

endmodule
